// ===== design/card_number_luhn_classifier_macros.svh =====
// Assertion helpers for the card number classifier.
`ifndef CARD_NUMBER_LUHN_CLASSIFIER_MACROS_SVH
`define CARD_NUMBER_LUHN_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CNLC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled in reset.
`define CNLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== design/cnlc_pkg.sv =====
package cnlc_pkg;

  localparam int NumBits   = 54;
  localparam int NumDigits = 17;
  localparam int CntW      = $clog2(NumBits);
  localparam int LenW      = $clog2(NumDigits + 1);

  localparam logic [1:0] BrandInvalid    = 2'd0;
  localparam logic [1:0] BrandMastercard = 2'd1;
  localparam logic [1:0] BrandAmex       = 2'd2;
  localparam logic [1:0] BrandVisa       = 2'd3;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StDrain,
    StFin
  } state_e;

  // Control broadcast to every digit cell.
  typedef struct packed {
    logic clr;
    logic dabble;
    logic drain;
  } cell_ctrl_t;

endpackage

// ===== design/cnlc_cell.sv =====
// One BCD digit of the conversion chain: add-3-and-shift during conversion,
// hand digits down toward the low end during drain.
module cnlc_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cnlc_pkg::cell_ctrl_t ctrl_i,
  input  logic                bit_i,
  input  logic [3:0]          digit_i,
  output logic                carry_o,
  output logic [3:0]          digit_o
);

  logic [3:0] digit_q, digit_d, adj;

  // Correct digits of five or more before the shift.
  assign adj     = (digit_q >= 4'd5) ? 4'(digit_q + 4'd3) : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clr) begin
      digit_d = 4'd0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.drain) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else begin
      digit_q <= digit_d;
    end
  end

endmodule

// ===== design/card_number_luhn_classifier.sv =====
// Operation: an accepted word passes through 54 binary to BCD shift steps
// in the 17-cell BCD digit chain, 17 drain steps and 1 decision step.
// A new word is taken only once control is back in idle after the decision,
// so a word is not taken before the last one is through; the decision step
// holds while an earlier result still waits on out_ready_i.
// Reset: asynchronous, active low; control returns to idle, no result held.
module card_number_luhn_classifier (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [53:0] card_number_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  brand_code_o
);

`include "card_number_luhn_classifier_macros.svh"

  localparam int NB = cnlc_pkg::NumBits;
  localparam int ND = cnlc_pkg::NumDigits;
  localparam int CW = cnlc_pkg::CntW;
  localparam int LW = cnlc_pkg::LenW;

  cnlc_pkg::state_e state_q, state_d;
  cnlc_pkg::cell_ctrl_t ctrl;

  logic [NB-1:0] shreg_q, shreg_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [3:0]    sum_q, sum_d, hi_q, hi_d, lo_q, lo_d, prev_q, prev_d;
  logic [LW-1:0] len_q, len_d;
  logic          out_valid_q, out_valid_d;
  logic [1:0]    brand_q, brand_d;

  logic          in_acc, out_acc, last_conv, last_drain, fin_go;
  logic [ND-1:0] carry;
  logic [3:0]    digit [ND];
  logic [3:0]    contrib, dbl;
  logic [4:0]    sum_raw;
  logic [1:0]    brand;

  assign in_acc     = in_valid_i && in_ready_o;
  assign out_acc    = out_valid_o && out_ready_i;
  assign last_conv  = (cnt_q == CW'(NB - 1));
  assign last_drain = (cnt_q == CW'(ND - 1));
  assign fin_go     = !out_valid_q || out_ready_i;

  // Digit chain.
  for (genvar i = 0; i < ND; i++) begin : g_cell
    logic       bit_in;
    logic [3:0] dig_in;
    if (i == 0) begin : g_lo
      assign bit_in = shreg_q[NB-1];
    end else begin : g_mid
      assign bit_in = carry[i-1];
    end
    if (i == ND - 1) begin : g_top
      assign dig_in = 4'd0;
    end else begin : g_dn
      assign dig_in = digit[i+1];
    end
    cnlc_cell u_cell (
      .clk_i,
      .rst_ni,
      .ctrl_i  (ctrl),
      .bit_i   (bit_in),
      .digit_i (dig_in),
      .carry_o (carry[i]),
      .digit_o (digit[i])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      cnlc_pkg::StIdle:  if (in_acc) state_d = cnlc_pkg::StConv;
      cnlc_pkg::StConv:  if (last_conv) state_d = cnlc_pkg::StDrain;
      cnlc_pkg::StDrain: if (last_drain) state_d = cnlc_pkg::StFin;
      cnlc_pkg::StFin:   if (fin_go) state_d = cnlc_pkg::StIdle;
      default:           state_d = cnlc_pkg::StIdle;
    endcase
  end

  // Outputs to the chain and handshake.
  always_comb begin
    ctrl       = '0;
    in_ready_o = 1'b0;
    case (state_q)
      cnlc_pkg::StIdle: begin
        in_ready_o = 1'b1;
        ctrl.clr   = in_acc;
      end
      cnlc_pkg::StConv:  ctrl.dabble = 1'b1;
      cnlc_pkg::StDrain: ctrl.drain  = 1'b1;
      default: ;
    endcase
  end

  // Luhn contribution of the digit leaving the low end.
  assign dbl     = (digit[0] >= 4'd5) ? 4'({digit[0], 1'b0} - 5'd9)
                                      : 4'({digit[0], 1'b0});
  assign contrib = cnt_q[0] ? dbl : digit[0];
  assign sum_raw = 5'(sum_q) + 5'(contrib);

  // Brand decision.
  always_comb begin
    brand = cnlc_pkg::BrandInvalid;
    if (sum_q == 4'd0) begin
      if (hi_q == 4'd5 && lo_q >= 4'd1 && lo_q <= 4'd5 && len_q == LW'(16)) begin
        brand = cnlc_pkg::BrandMastercard;
      end else if (hi_q == 4'd3 && (lo_q == 4'd4 || lo_q == 4'd7)
                   && len_q == LW'(15)) begin
        brand = cnlc_pkg::BrandAmex;
      end else if (hi_q == 4'd4 && (len_q == LW'(13) || len_q == LW'(16))) begin
        brand = cnlc_pkg::BrandVisa;
      end
    end
  end

  // Datapath next values.
  always_comb begin
    shreg_d     = shreg_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    hi_d        = hi_q;
    lo_d        = lo_q;
    prev_d      = prev_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && !out_acc;
    brand_d     = brand_q;
    case (state_q)
      cnlc_pkg::StIdle: begin
        if (in_acc) begin
          shreg_d = card_number_i;
          cnt_d   = '0;
        end
      end
      cnlc_pkg::StConv: begin
        shreg_d = {shreg_q[NB-2:0], 1'b0};
        cnt_d   = last_conv ? '0 : CW'(cnt_q + 1'b1);
        sum_d   = 4'd0;
        hi_d    = 4'd0;
        lo_d    = 4'd0;
        prev_d  = 4'd0;
        len_d   = '0;
      end
      cnlc_pkg::StDrain: begin
        cnt_d  = CW'(cnt_q + 1'b1);
        sum_d  = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
        prev_d = digit[0];
        if (digit[0] != 4'd0) begin
          hi_d  = digit[0];
          lo_d  = prev_q;
          len_d = LW'(cnt_q + 1'b1);
        end
      end
      cnlc_pkg::StFin: begin
        if (fin_go) begin
          out_valid_d = 1'b1;
          brand_d     = brand;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cnlc_pkg::StIdle;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    sum_q   <= sum_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    prev_q  <= prev_d;
    len_q   <= len_d;
    brand_q <= brand_d;
  end

  assign out_valid_o  = out_valid_q;
  assign brand_code_o = brand_q;

  `CNLC_ASSERT_NEXT(a_accept_starts_conv, clk_i, rst_ni, in_acc, state_q == cnlc_pkg::StConv)
  `CNLC_ASSERT_NEXT(a_drain_to_fin, clk_i, rst_ni,
    state_q == cnlc_pkg::StDrain && last_drain, state_q == cnlc_pkg::StFin)
  `CNLC_ASSERT_NEXT(a_fin_waits, clk_i, rst_ni,
    state_q == cnlc_pkg::StFin && !fin_go, state_q == cnlc_pkg::StFin && out_valid_q)
  `CNLC_ASSERT_IMPL(a_conv_cnt_range, clk_i, rst_ni,
    state_q == cnlc_pkg::StDrain, cnt_q < CW'(ND))

endmodule
